@@ hw/rtl/mst_pkg.sv @@
// shared types and constants for the multi-slot interval timer
package mst_pkg;

   localparam int NUM_SLOTS_DEF = 8;
   localparam int SLOT_W        = 3;
   localparam int MASK_W        = 8;
   localparam int TIME_W        = 32;

   typedef enum logic [2:0] {
      OP_CREATE = 3'd0,
      OP_DELETE = 3'd1,
      OP_START  = 3'd2,
      OP_STOP   = 3'd3,
      OP_TICK   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   // one transaction as it walks down the row of slot cells
   typedef struct packed {
      logic               valid;
      op_type             opcode;
      logic [SLOT_W-1:0]  slot;
      logic [TIME_W-1:0]  target;
      logic               periodic;
      logic [TIME_W-1:0]  now;
      status_type         status;
      logic [SLOT_W-1:0]  slot_out;
      logic [MASK_W-1:0]  mask;
   } token_type;

endpackage

@@ hw/rtl/multi_slot_interval_timer_core.sv @@
// top level: pool of interval timer slots built as a row of slot cells
// Each transaction enters the first slot cell and moves one cell per cycle down a
// row of NUM_SLOTS cells; each cell owns one timer slot and updates it as the
// transaction passes, so create finds the lowest free slot and tick collects the
// expired mask along the way. The last cell's register is the result register.
// A transaction crosses the NUM_SLOTS cell registers to reach rsp_valid; a new one is
// taken every cycle while results are being taken, and the whole row holds when
// rsp_ready is low with a result waiting. Only slots 0 to 7 can be named by
// req_slot or reported in rsp_expired_mask.
module multi_slot_interval_timer_core #(
   parameter int NUM_SLOTS = mst_pkg::NUM_SLOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_opcode,
   input  logic [mst_pkg::SLOT_W-1:0]  req_slot,
   input  logic [mst_pkg::TIME_W-1:0]  req_target_time,
   input  logic                        req_periodic,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [mst_pkg::SLOT_W-1:0]  rsp_slot_out,
   output logic [mst_pkg::MASK_W-1:0]  rsp_expired_mask
);

   mst_pkg::token_type          chain [NUM_SLOTS+1];
   mst_pkg::token_type          entry;
   mst_pkg::op_type             op;
   logic [mst_pkg::TIME_W-1:0]  now_ff, now_in;
   logic                        advance;
   logic                        out_of_range;

   assign advance   = !chain[NUM_SLOTS].valid || rsp_ready;
   assign req_ready = advance;
   assign op        = mst_pkg::op_type'(req_opcode);

   assign out_of_range = (32'(req_slot) >= 32'(NUM_SLOTS));

   always_comb begin
      now_in = now_ff;
      if (req_valid && advance && op == mst_pkg::OP_TICK) begin
         now_in = now_ff + mst_pkg::TIME_W'(1);
      end
   end

   always_comb begin
      entry.valid    = req_valid;
      entry.opcode   = op;
      entry.slot     = req_slot;
      entry.target   = req_target_time;
      entry.periodic = req_periodic;
      entry.now      = (op == mst_pkg::OP_TICK) ? now_ff + mst_pkg::TIME_W'(1) : now_ff;
      entry.status   = mst_pkg::ST_OK;
      entry.slot_out = req_slot;
      entry.mask     = '0;
      unique case (op)
         mst_pkg::OP_CREATE: begin
            // stays full unless some cell claims it
            entry.status   = mst_pkg::ST_FULL;
            entry.slot_out = '0;
         end
         mst_pkg::OP_DELETE, mst_pkg::OP_START, mst_pkg::OP_STOP: begin
            if (out_of_range) begin
               entry.status = mst_pkg::ST_RANGE;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff <= '0;
      end else begin
         now_ff <= now_in;
      end
   end

   assign chain[0] = entry;

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      mst_cell #(
         .SLOT_INDEX (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .in_tok  (chain[i]),
         .out_tok (chain[i+1])
      );
   end

   assign rsp_valid        = chain[NUM_SLOTS].valid;
   assign rsp_status       = chain[NUM_SLOTS].status;
   assign rsp_slot_out     = chain[NUM_SLOTS].slot_out;
   assign rsp_expired_mask = chain[NUM_SLOTS].mask;

endmodule

@@ hw/rtl/mst_cell.sv @@
// one timer slot: holds the slot state and processes each passing transaction
module mst_cell #(
   parameter int SLOT_INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  mst_pkg::token_type in_tok,
   output mst_pkg::token_type out_tok
);

   localparam bit REPORTABLE = (SLOT_INDEX < mst_pkg::MASK_W);
   localparam logic [mst_pkg::MASK_W-1:0] MY_BIT =
      REPORTABLE ? (mst_pkg::MASK_W'(1) << SLOT_INDEX) : '0;

   logic                        alloc_ff, alloc_in;
   logic                        run_ff, run_in;
   logic                        rpt_ff, rpt_in;
   logic [mst_pkg::TIME_W-1:0]  stamp_ff, stamp_in;
   logic [mst_pkg::TIME_W-1:0]  ivl_ff, ivl_in;
   mst_pkg::token_type          out_tok_ff, out_tok_in;
   logic [mst_pkg::TIME_W-1:0]  elapsed;
   logic                        hit;
   logic                        slot_ok;

   assign elapsed = in_tok.now - stamp_ff;
   assign hit     = REPORTABLE &&
                    (in_tok.slot == mst_pkg::SLOT_W'(SLOT_INDEX));
   assign slot_ok = hit && (in_tok.status == mst_pkg::ST_OK);

   always_comb begin
      alloc_in   = alloc_ff;
      run_in     = run_ff;
      rpt_in     = rpt_ff;
      stamp_in   = stamp_ff;
      ivl_in     = ivl_ff;
      out_tok_in = in_tok;
      if (in_tok.valid) begin
         unique case (in_tok.opcode)
            mst_pkg::OP_CREATE: begin
               // first free cell along the row takes the create
               if (in_tok.status == mst_pkg::ST_FULL && !alloc_ff) begin
                  alloc_in            = 1'b1;
                  run_in              = 1'b0;
                  rpt_in              = 1'b0;
                  out_tok_in.status   = mst_pkg::ST_OK;
                  out_tok_in.slot_out = mst_pkg::SLOT_W'(SLOT_INDEX);
               end
            end
            mst_pkg::OP_DELETE: begin
               if (slot_ok) begin
                  alloc_in = 1'b0;
                  run_in   = 1'b0;
               end
            end
            mst_pkg::OP_START: begin
               if (slot_ok) begin
                  stamp_in = in_tok.now;
                  ivl_in   = in_tok.target;
                  run_in   = 1'b1;
                  rpt_in   = in_tok.periodic;
               end
            end
            mst_pkg::OP_STOP: begin
               if (slot_ok) begin
                  run_in = 1'b0;
                  rpt_in = 1'b0;
               end
            end
            mst_pkg::OP_TICK: begin
               // now already carries the incremented time
               if (run_ff && elapsed >= ivl_ff) begin
                  if (rpt_ff) begin
                     stamp_in = in_tok.now;
                  end else begin
                     run_in = 1'b0;
                  end
                  if (alloc_ff) begin
                     out_tok_in.mask = in_tok.mask | MY_BIT;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff   <= 1'b0;
         run_ff     <= 1'b0;
         rpt_ff     <= 1'b0;
         out_tok_ff <= '0;
      end else if (advance) begin
         alloc_ff   <= alloc_in;
         run_ff     <= run_in;
         rpt_ff     <= rpt_in;
         out_tok_ff <= out_tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stamp_ff <= stamp_in;
         ivl_ff   <= ivl_in;
      end
   end

   assign out_tok = out_tok_ff;

endmodule

@@ dv/multi_slot_interval_timer_core_checker.sv @@
// checker for the interval timer pool: predicts each response and compares it with the block
module multi_slot_interval_timer_core_checker #(
   parameter int NUM_SLOTS = mst_pkg::NUM_SLOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [2:0]                  req_opcode,
   input  logic [mst_pkg::SLOT_W-1:0]  req_slot,
   input  logic [mst_pkg::TIME_W-1:0]  req_target_time,
   input  logic                        req_periodic,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [1:0]                  rsp_status,
   input  logic [mst_pkg::SLOT_W-1:0]  rsp_slot_out,
   input  logic [mst_pkg::MASK_W-1:0]  rsp_expired_mask,
   output int                          mismatch_count,
   output int                          pending
);

   typedef struct {
      mst_pkg::status_type         status;
      logic [mst_pkg::SLOT_W-1:0]  slot_out;
      logic [mst_pkg::MASK_W-1:0]  mask;
   } pool_reply_type;

   logic                       slot_allocated [NUM_SLOTS];
   logic                       slot_running   [NUM_SLOTS];
   logic                       slot_repeat    [NUM_SLOTS];
   logic [mst_pkg::TIME_W-1:0] slot_stamp     [NUM_SLOTS];
   logic [mst_pkg::TIME_W-1:0] slot_interval  [NUM_SLOTS];
   logic [mst_pkg::TIME_W-1:0] pool_now;
   pool_reply_type             reply_queue[$];

   // applies one command to the shadow pool and returns the reply it should produce
   function automatic pool_reply_type advance_pool(logic [2:0] opcode,
                                                   logic [mst_pkg::SLOT_W-1:0] slot,
                                                   logic [mst_pkg::TIME_W-1:0] target,
                                                   logic per);
      pool_reply_type r;
      int             idx;
      r.status   = mst_pkg::ST_OK;
      r.slot_out = slot;
      r.mask     = '0;
      idx        = int'(slot);
      case (opcode)
         mst_pkg::OP_CREATE: begin
            r.status   = mst_pkg::ST_FULL;
            r.slot_out = '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (!slot_allocated[i]) begin
                  slot_allocated[i] = 1'b1;
                  slot_running[i]   = 1'b0;
                  slot_repeat[i]    = 1'b0;
                  r.status          = mst_pkg::ST_OK;
                  r.slot_out        = mst_pkg::SLOT_W'(i);
                  break;
               end
            end
         end
         mst_pkg::OP_DELETE, mst_pkg::OP_START, mst_pkg::OP_STOP: begin
            if (idx >= NUM_SLOTS) begin
               r.status = mst_pkg::ST_RANGE;
            end else if (opcode == mst_pkg::OP_DELETE) begin
               slot_allocated[idx] = 1'b0;
               slot_running[idx]   = 1'b0;
            end else if (opcode == mst_pkg::OP_START) begin
               slot_stamp[idx]    = pool_now;
               slot_interval[idx] = target;
               slot_running[idx]  = 1'b1;
               slot_repeat[idx]   = per;
            end else begin
               slot_running[idx] = 1'b0;
               slot_repeat[idx]  = 1'b0;
            end
         end
         mst_pkg::OP_TICK: begin
            pool_now = pool_now + 1'b1;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               // elapsed time wraps modulo 2^32
               if (slot_running[i] &&
                   (mst_pkg::TIME_W'(pool_now - slot_stamp[i]) >= slot_interval[i]))
               begin
                  if (slot_repeat[i])
                     slot_stamp[i] = pool_now;
                  else
                     slot_running[i] = 1'b0;
                  // unallocated slots still expire but stay out of the mask
                  if (slot_allocated[i] && i < mst_pkg::MASK_W)
                     r.mask[i] = 1'b1;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic check_field(string field, int expected_value, int actual_value);
      if (expected_value != actual_value) begin
         mismatch_count++;
         $display("%0t: %s mismatch: expected %0d, actual %0d",
                  $time, field, expected_value, actual_value);
      end
   endtask

   always @(posedge clock) begin
      pool_reply_type expected;
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_allocated[i] = 1'b0;
            slot_running[i]   = 1'b0;
            slot_repeat[i]    = 1'b0;
            slot_stamp[i]     = '0;
            slot_interval[i]  = '0;
         end
         pool_now = '0;
         reply_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (reply_queue.size() == 0) begin
               mismatch_count++;
               $display("%0t: response with nothing expected: status %0d slot_out %0d mask %0d",
                        $time, rsp_status, rsp_slot_out, rsp_expired_mask);
            end else begin
               expected = reply_queue.pop_front();
               check_field("status", expected.status, rsp_status);
               check_field("slot_out", expected.slot_out, rsp_slot_out);
               check_field("expired_mask", expected.mask, rsp_expired_mask);
            end
         end
         // response side first so a same-cycle transaction cannot hide a stray response
         if (req_valid && req_ready)
            reply_queue.push_back(advance_pool(req_opcode, req_slot, req_target_time,
                                               req_periodic));
      end
      pending = reply_queue.size();
   end

endmodule

@@ dv/multi_slot_interval_timer_core_tb.sv @@
// testbench top for the interval timer pool: clock, reset, command stimulus and verdict
module multi_slot_interval_timer_core_tb;

   localparam int          NUM_SLOTS      = mst_pkg::NUM_SLOTS_DEF;
   localparam int          RANDOM_ITEMS   = 1050;
   localparam int          BURST_ITEMS    = 40;
   localparam int          LONG_HOLD      = 80;
   localparam int          CYCLE_LIMIT    = 400000;
   localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [2:0]                  req_opcode;
   logic [mst_pkg::SLOT_W-1:0]  req_slot;
   logic [mst_pkg::TIME_W-1:0]  req_target_time;
   logic                        req_periodic;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [1:0]                  rsp_status;
   logic [mst_pkg::SLOT_W-1:0]  rsp_slot_out;
   logic [mst_pkg::MASK_W-1:0]  rsp_expired_mask;
   int                          mismatch_count;
   int                          pending;
   int                          cycle_count;
   logic                        hold_request;
   logic                        hold_done;
   logic                        no_gaps;

   multi_slot_interval_timer_core #(.NUM_SLOTS(NUM_SLOTS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_slot(req_slot), .req_target_time(req_target_time), .req_periodic(req_periodic),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_slot_out(rsp_slot_out), .rsp_expired_mask(rsp_expired_mask)
   );

   multi_slot_interval_timer_core_checker #(.NUM_SLOTS(NUM_SLOTS)) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_slot(req_slot), .req_target_time(req_target_time), .req_periodic(req_periodic),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_slot_out(rsp_slot_out), .rsp_expired_mask(rsp_expired_mask),
      .mismatch_count(mismatch_count), .pending(pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL multi_slot_interval_timer_core");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // called at a falling edge; returns at the falling edge after the transaction is taken
   task automatic send_command(logic [2:0] opcode, logic [mst_pkg::SLOT_W-1:0] slot,
                               logic [mst_pkg::TIME_W-1:0] target, logic per);
      int gap;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= opcode;
      req_slot        <= slot;
      req_target_time <= target;
      req_periodic    <= per;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic issue_random_command();
      int                          roll;
      int                          tsel;
      logic [2:0]                  opcode;
      logic [mst_pkg::TIME_W-1:0]  target;
      roll = $urandom_range(0, 99);
      if (roll < 12)
         opcode = mst_pkg::OP_CREATE;
      else if (roll < 20)
         opcode = mst_pkg::OP_DELETE;
      else if (roll < 45)
         opcode = mst_pkg::OP_START;
      else if (roll < 53)
         opcode = mst_pkg::OP_STOP;
      else if (roll < 96)
         opcode = mst_pkg::OP_TICK;
      else
         opcode = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      // short intervals so that ticks expire slots often
      tsel = $urandom_range(0, 9);
      if (tsel < 7)
         target = $urandom_range(0, 6);
      else if (tsel < 9)
         target = $urandom_range(7, 40);
      else
         target = $urandom();
      send_command(opcode, mst_pkg::SLOT_W'($urandom_range(0, NUM_SLOTS - 1)), target,
                   1'($urandom_range(0, 1)));
   endtask

   // response side: random stalls plus one long hold-off on request
   initial begin
      int stall;
      int run;
      rsp_ready = 1'b0;
      hold_done = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            stall = pick_gap();
            run   = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
            rsp_ready <= 1'b1;
            repeat (run) @(negedge clock);
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_opcode      = mst_pkg::OP_TICK;
      req_slot        = '0;
      req_target_time = '0;
      req_periodic    = 1'b0;
      hold_request    = 1'b0;
      no_gaps         = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed part
      send_command(mst_pkg::OP_TICK, 3'd0, '0, 1'b0);
      for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
         send_command(3'(op), 3'(op), '1, 1'b1);
      // running but unallocated slot expires silently
      send_command(mst_pkg::OP_START, 3'd2, '0, 1'b1);
      send_command(mst_pkg::OP_TICK, 3'd0, '0, 1'b0);
      for (int i = 0; i < NUM_SLOTS; i++)
         send_command(mst_pkg::OP_CREATE, 3'd7, '0, 1'b0);
      // pool full
      send_command(mst_pkg::OP_CREATE, 3'd0, '0, 1'b0);
      send_command(mst_pkg::OP_DELETE, 3'd6, '0, 1'b0);
      send_command(mst_pkg::OP_START, 3'd6, '0, 1'b1);
      // zero interval fires on every tick
      send_command(mst_pkg::OP_START, 3'd0, '0, 1'b1);
      send_command(mst_pkg::OP_START, 3'd1, 32'd2, 1'b0);
      send_command(mst_pkg::OP_START, 3'd7, '1, 1'b1);
      send_command(mst_pkg::OP_START, 3'd4, 32'h5555_aaaa, 1'b0);
      repeat (3) send_command(mst_pkg::OP_TICK, 3'd0, '0, 1'b0);
      send_command(mst_pkg::OP_STOP, 3'd0, '0, 1'b0);
      send_command(mst_pkg::OP_DELETE, 3'd7, '0, 1'b0);
      send_command(mst_pkg::OP_TICK, 3'd0, '0, 1'b0);

      req_valid <= 1'b0;
      wait (pending == 0);
      @(negedge clock);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 300) begin
            // back up the pipeline behind a long response stall
            hold_request = 1'b1;
            no_gaps      = 1'b1;
         end
         if (n == 300 + BURST_ITEMS)
            no_gaps = 1'b0;
         if (n == 600) begin
            req_valid <= 1'b0;
            wait (pending == 0);
            @(negedge clock);
         end
         issue_random_command();
      end

      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (4 * NUM_SLOTS) @(posedge clock);
      if (mismatch_count == 0 && pending == 0)
         $display("PASS multi_slot_interval_timer_core");
      else
         $display("FAIL multi_slot_interval_timer_core");
      $finish;
   end

endmodule
